### sv/accdr_pkg.sv
// Types and constants shared by the decoder refresh scheduler modules.
package accdr_pkg;

    localparam int ENT_W  = 6;    // width of the entry field
    localparam int ECNT_W = 7;    // width of the entry_count register
    localparam int LCNT_W = 11;   // width of the loco_count register
    localparam int CFG_W  = 11;   // widest configuration register

    localparam logic [3:0] SEQ_LEN = 4'd10;

    // input kinds
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_WRITE = 3'd1;
    localparam logic [2:0] KIND_BIND  = 3'd2;
    localparam logic [2:0] KIND_FTYPE = 3'd3;
    localparam logic [2:0] KIND_SETF  = 3'd4;

    // packet kinds
    localparam logic [2:0] PK_SPEED  = 3'd0;
    localparam logic [2:0] PK_F0_4   = 3'd1;
    localparam logic [2:0] PK_F5_8   = 3'd2;
    localparam logic [2:0] PK_F9_12  = 3'd3;
    localparam logic [2:0] PK_F13_20 = 3'd4;
    localparam logic [2:0] PK_F21_28 = 3'd5;
    localparam logic [2:0] PK_F29_36 = 3'd6;

    // lowest function number of each gated group
    localparam logic [4:0] TOP_F5  = 5'd5;
    localparam logic [4:0] TOP_F9  = 5'd9;
    localparam logic [4:0] TOP_F13 = 5'd13;
    localparam logic [4:0] TOP_F21 = 5'd21;

    // highest function number of each group but the last
    localparam logic [4:0] GRP_END_1 = 5'd4;
    localparam logic [4:0] GRP_END_2 = 5'd8;
    localparam logic [4:0] GRP_END_3 = 5'd12;
    localparam logic [4:0] GRP_END_4 = 5'd20;
    localparam logic [4:0] GRP_END_5 = 5'd28;

    // configuration register indexes
    localparam logic CFG_ENTRY_COUNT = 1'b0;
    localparam logic CFG_LOCO_COUNT  = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK_IDLE,
        OP_SERVE,
        OP_WRITE,
        OP_UNBIND,
        OP_BIND,
        OP_FTYPE,
        OP_SETF
    } t_op;

    typedef struct packed {
        logic [13:0] addr;
        logic        active;
        logic [4:0]  top;
        logic [31:0] pulse;
        logic [31:0] func;
        logic [3:0]  seq;
        logic        bound;
        logic [9:0]  loco;
    } t_entry;

    typedef struct packed {
        logic [5:0]  entry;
        logic [13:0] dcc_address;
        logic        enable;
        logic [9:0]  loco_number;
        logic        unbind;
        logic [4:0]  function_number;
        logic        flag;
    } t_item;

    typedef struct packed {
        logic        packet_valid;
        logic [2:0]  packet_kind;
        logic [5:0]  served_entry;
        logic [13:0] packet_address;
        logic [9:0]  speed_source_loco;
        logic [31:0] function_bits;
        logic        pulse_reset_request;
        logic        cycle_done;
    } t_result;

    typedef struct packed {
        logic    we;
        t_entry  data;
        t_result res;
    } t_exec_out;

endpackage

### sv/accessory_decoder_refresh_scheduler.sv
// Refresh scheduler for a table of function decoder entries.
//
// Input stream (s side): one word per command; tuser carries the kind (tick, write
// entry, bind loco, set function type, set function), tdata the operands. Every
// accepted word yields exactly one output word on the m side: packet fields in
// tdata, packet kind in tuser.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index (0 entry
// count, 1 loco count) on the clock edge; write only while the block is idle.
//
// Timing: a word is taken in the idle state, decoded in the next cycle (table read
// issued), and then executed (read-modify-write of one table entry and loading of
// the output register). A bind first walks the table one entry per cycle through
// the read port to unbind the loco from the other entries in use.
// The result sits in an output register; the next word is taken while it waits.
// If the receiver stalls, the following command holds in its execute cycle until
// the output register frees up.
// Reset (synchronous, active low) clears the entry valid bits, so every entry
// reads as all zero, along with the round robin pointer, tick phase and registers.
module accessory_decoder_refresh_scheduler #(
    parameter int ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // entry, dcc_address, enable, loco_number, unbind, function_number, flag, zero pad
    input  logic [39:0] i_s_tdata,
    // kind
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // packet_valid, served_entry, packet_address, speed_source_loco, function_bits,
    // pulse_reset_request, cycle_done, zero pad
    output logic [71:0] o_m_tdata,
    // packet_kind
    output logic [2:0]  o_m_tuser,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [accdr_pkg::CFG_W-1:0] i_cfg_data
);
    import accdr_pkg::*;

    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [ECNT_W-1:0] r_entry_count;
    logic [LCNT_W-1:0] r_loco_count;

    t_item     in_item;
    t_result   out_res;
    t_item     ex_item;
    t_op       ex_op;
    logic [5:0] ex_ent;
    t_exec_out ex_out;

    logic          rd_en;
    logic [EW-1:0] rd_addr;
    t_entry        rd_data;
    logic          wr_en;
    logic [EW-1:0] wr_addr;
    t_entry        wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_loco_count  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data[ECNT_W-1:0];
                CFG_LOCO_COUNT:  r_loco_count  <= i_cfg_data[LCNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_item.entry           = i_s_tdata[5:0];
    assign in_item.dcc_address     = i_s_tdata[19:6];
    assign in_item.enable          = i_s_tdata[20];
    assign in_item.loco_number     = i_s_tdata[30:21];
    assign in_item.unbind          = i_s_tdata[31];
    assign in_item.function_number = i_s_tdata[36:32];
    assign in_item.flag            = i_s_tdata[37];

    assign o_m_tdata = {7'd0, out_res.cycle_done, out_res.pulse_reset_request,
                        out_res.function_bits, out_res.speed_source_loco,
                        out_res.packet_address, out_res.served_entry,
                        out_res.packet_valid};
    assign o_m_tuser = out_res.packet_kind;

    accdr_seq #(
        .ENTRIES (ENTRIES),
        .EW      (EW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_count (r_entry_count),
        .i_loco_count  (r_loco_count),
        .i_in_valid    (i_s_tvalid),
        .o_in_ready    (o_s_tready),
        .i_kind        (i_s_tuser),
        .i_item        (in_item),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_out         (out_res),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_op          (ex_op),
        .o_item        (ex_item),
        .o_ent         (ex_ent),
        .i_exec        (ex_out)
    );

    accdr_exec u_exec (
        .i_op   (ex_op),
        .i_item (ex_item),
        .i_ent  (ex_ent),
        .i_rd   (rd_data),
        .o_out  (ex_out)
    );

    accdr_table #(
        .ENTRIES (ENTRIES),
        .EW      (EW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

endmodule

### sv/accdr_table.sv
// Entry table memory: one read and one write port, registered read, per-entry valid bits.
module accdr_table #(
    parameter int ENTRIES = 64,
    parameter int EW      = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [EW-1:0]      i_rd_addr,
    output accdr_pkg::t_entry  o_rd_data,
    input  logic               i_wr_en,
    input  logic [EW-1:0]      i_wr_addr,
    input  accdr_pkg::t_entry  i_wr_data
);
    import accdr_pkg::*;

    t_entry r_mem [ENTRIES];
    logic   r_valid [ENTRIES];
    t_entry r_q;
    logic   r_qv;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ENTRIES; k++) begin
                r_valid[k] <= 1'b0;
            end
            r_qv <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_qv <= r_valid[i_rd_addr];
            end
        end
    end

    // entries not written since reset read as all zero
    assign o_rd_data = r_qv ? r_q : '0;

endmodule

### sv/accdr_exec.sv
// Read-modify-write unit: new entry contents and the packet for one operation.
module accdr_exec (
    input  accdr_pkg::t_op       i_op,
    input  accdr_pkg::t_item     i_item,
    input  logic [5:0]           i_ent,
    input  accdr_pkg::t_entry    i_rd,
    output accdr_pkg::t_exec_out o_out
);
    import accdr_pkg::*;

    function automatic t_result emit(input logic [2:0] kind, input t_entry ent,
                                     input logic [5:0] idx);
        t_result r;
        r = '0;
        r.packet_valid   = 1'b1;
        r.packet_kind    = kind;
        r.served_entry   = idx;
        r.packet_address = ent.addr;
        if (kind == PK_SPEED) begin
            r.speed_source_loco = ent.loco;
        end else begin
            r.function_bits = ent.func;
        end
        return r;
    endfunction

    logic [31:0] mask;
    logic [3:0]  pos_inc;
    logic [2:0]  group;

    assign mask    = 32'd1 << i_item.function_number;
    assign pos_inc = i_rd.seq + 4'd1;

    always_comb begin
        if (i_item.function_number <= GRP_END_1) begin
            group = PK_F0_4;
        end else if (i_item.function_number <= GRP_END_2) begin
            group = PK_F5_8;
        end else if (i_item.function_number <= GRP_END_3) begin
            group = PK_F9_12;
        end else if (i_item.function_number <= GRP_END_4) begin
            group = PK_F13_20;
        end else if (i_item.function_number <= GRP_END_5) begin
            group = PK_F21_28;
        end else begin
            group = PK_F29_36;
        end
    end

    always_comb begin
        o_out      = '0;
        o_out.data = i_rd;
        case (i_op)
            OP_SERVE: begin
                if (i_rd.active && i_rd.addr != '0) begin
                    o_out.we = 1'b1;
                    if (!i_rd.seq[0]) begin
                        if (i_rd.bound) begin
                            o_out.res = emit(PK_SPEED, i_rd, i_ent);
                        end
                    end else if (i_rd.seq == 4'd1) begin
                        o_out.res = emit(PK_F0_4, i_rd, i_ent);
                    end else if (i_rd.seq == 4'd3) begin
                        if (i_rd.top >= TOP_F5) o_out.res = emit(PK_F5_8, i_rd, i_ent);
                    end else if (i_rd.seq == 4'd5) begin
                        if (i_rd.top >= TOP_F9) o_out.res = emit(PK_F9_12, i_rd, i_ent);
                    end else if (i_rd.seq == 4'd7) begin
                        if (i_rd.top >= TOP_F13) o_out.res = emit(PK_F13_20, i_rd, i_ent);
                    end else if (i_rd.seq == 4'd9) begin
                        if (i_rd.top >= TOP_F21) o_out.res = emit(PK_F21_28, i_rd, i_ent);
                    end
                    o_out.data.seq = (pos_inc >= SEQ_LEN) ? 4'd0 : pos_inc;
                end
            end
            OP_WRITE: begin
                o_out.we          = 1'b1;
                o_out.data.addr   = i_item.dcc_address;
                o_out.data.active = i_item.enable;
            end
            OP_UNBIND: begin
                o_out.we         = 1'b1;
                o_out.data.bound = 1'b0;
            end
            OP_BIND: begin
                o_out.we         = 1'b1;
                o_out.data.bound = 1'b1;
                o_out.data.loco  = i_item.loco_number;
            end
            OP_FTYPE: begin
                o_out.we = 1'b1;
                if (i_rd.top < i_item.function_number) begin
                    o_out.data.top = i_item.function_number;
                end
                o_out.data.pulse = i_item.flag ? (i_rd.pulse | mask) : (i_rd.pulse & ~mask);
            end
            OP_SETF: begin
                o_out.we        = 1'b1;
                o_out.data.func = i_item.flag ? (i_rd.func | mask) : (i_rd.func & ~mask);
                o_out.res       = emit(group, o_out.data, i_ent);
                o_out.res.pulse_reset_request = i_item.flag && ((mask & i_rd.pulse) != '0);
            end
            default: ;
        endcase
    end

endmodule

### sv/accdr_seq.sv
// Sequencer: decodes a word, drives table reads and writes, walks entries on bind.
module accdr_seq #(
    parameter int ENTRIES = 64,
    parameter int EW      = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [accdr_pkg::ECNT_W-1:0] i_entry_count,
    input  logic [accdr_pkg::LCNT_W-1:0] i_loco_count,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [2:0]               i_kind,
    input  accdr_pkg::t_item         i_item,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output accdr_pkg::t_result       o_out,
    output logic                     o_rd_en,
    output logic [EW-1:0]            o_rd_addr,
    input  accdr_pkg::t_entry        i_rd_data,
    output logic                     o_wr_en,
    output logic [EW-1:0]            o_wr_addr,
    output accdr_pkg::t_entry        o_wr_data,
    output accdr_pkg::t_op           o_op,
    output accdr_pkg::t_item         o_item,
    output logic [5:0]               o_ent,
    input  accdr_pkg::t_exec_out     i_exec
);
    import accdr_pkg::*;

    localparam int NW = $clog2(ENTRIES + 1);
    localparam int CW = (NW > ECNT_W) ? NW : ECNT_W;
    localparam int XW = (EW > ENT_W) ? EW : ENT_W;

    typedef enum logic [1:0] {S_IDLE, S_DECODE, S_WALK, S_EXEC} t_state;

    t_state        r_state, n_state;
    t_item         r_item, n_item;
    logic [2:0]    r_kind, n_kind;
    t_op           r_op, n_op;
    logic [EW-1:0] r_idx, n_idx;
    logic [EW-1:0] r_i, n_i;
    logic [1:0]    r_phase, n_phase;
    logic [EW-1:0] r_next, n_next;
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;

    logic [CW-1:0] in_use;
    logic [CW-1:0] next_inc;
    logic [CW-1:0] walk_inc;
    logic          ent_ok;
    logic [XW-1:0] ent_x;
    logic [EW-1:0] ent_idx;
    logic [XW-1:0] idx_x;
    logic          out_free;

    assign in_use   = (CW'(i_entry_count) < CW'(ENTRIES)) ? CW'(i_entry_count) : CW'(ENTRIES);
    assign next_inc = CW'(r_next) + CW'(1);
    assign walk_inc = CW'(r_i) + CW'(1);
    assign ent_ok   = CW'(r_item.entry) < CW'(ENTRIES);
    assign ent_x    = XW'(r_item.entry);
    assign ent_idx  = ent_x[EW-1:0];
    assign idx_x    = XW'(r_idx);
    assign out_free = !r_out_valid || i_out_ready;

    assign o_in_ready  = i_rst_n && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_op        = r_op;
    assign o_item      = r_item;
    assign o_ent       = idx_x[5:0];

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_kind      = r_kind;
        n_op        = r_op;
        n_idx       = r_idx;
        n_i         = r_i;
        n_phase     = r_phase;
        n_next      = r_next;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_idx;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_i;
        o_wr_data   = i_rd_data;
        o_wr_data.bound = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_item;
                    n_kind  = i_kind;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_EXEC;
                n_op    = OP_NONE;
                n_idx   = ent_idx;
                case (r_kind)
                    KIND_TICK: begin
                        if (r_phase == 2'd0 && CW'(r_next) < in_use) begin
                            n_op      = OP_SERVE;
                            n_idx     = r_next;
                            o_rd_en   = 1'b1;
                            o_rd_addr = r_next;
                        end else begin
                            n_op = OP_TICK_IDLE;
                        end
                    end
                    KIND_WRITE, KIND_FTYPE, KIND_SETF: begin
                        if (ent_ok) begin
                            case (r_kind)
                                KIND_WRITE: n_op = OP_WRITE;
                                KIND_FTYPE: n_op = OP_FTYPE;
                                default:    n_op = OP_SETF;
                            endcase
                            o_rd_en   = 1'b1;
                            o_rd_addr = ent_idx;
                        end
                    end
                    KIND_BIND: begin
                        if (ent_ok) begin
                            if (r_item.unbind) begin
                                n_op      = OP_UNBIND;
                                o_rd_en   = 1'b1;
                                o_rd_addr = ent_idx;
                            end else if (LCNT_W'(r_item.loco_number) < i_loco_count) begin
                                n_op    = OP_BIND;
                                o_rd_en = 1'b1;
                                if (in_use != '0) begin
                                    // clear this loco from every other entry in use first
                                    o_rd_addr = '0;
                                    n_i       = '0;
                                    n_state   = S_WALK;
                                end else begin
                                    o_rd_addr = ent_idx;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_WALK: begin
                if (i_rd_data.bound && i_rd_data.loco == r_item.loco_number && r_i != r_idx) begin
                    o_wr_en = 1'b1;
                end
                o_rd_en = 1'b1;
                if (walk_inc < in_use) begin
                    o_rd_addr = r_i + EW'(1);
                    n_i       = r_i + EW'(1);
                end else begin
                    o_rd_addr = r_idx;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_wr_en     = i_exec.we;
                    o_wr_addr   = r_idx;
                    o_wr_data   = i_exec.data;
                    n_out       = i_exec.res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_op == OP_SERVE || r_op == OP_TICK_IDLE) begin
                        n_phase          = r_phase + 2'd1;
                        n_out.cycle_done = 1'b1;
                        if (r_op == OP_SERVE) begin
                            if (next_inc >= in_use) begin
                                n_next = '0;
                            end else begin
                                n_next           = next_inc[EW-1:0];
                                n_out.cycle_done = 1'b0;
                            end
                        end else if (r_phase == 2'd0) begin
                            n_next = '0;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_item      <= '0;
            r_kind      <= KIND_TICK;
            r_op        <= OP_NONE;
            r_idx       <= '0;
            r_i         <= '0;
            r_phase     <= 2'd0;
            r_next      <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            r_state     <= n_state;
            r_item      <= n_item;
            r_kind      <= n_kind;
            r_op        <= n_op;
            r_idx       <= n_idx;
            r_i         <= n_i;
            r_phase     <= n_phase;
            r_next      <= n_next;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

endmodule

### test/refresh_monitor.sv
`timescale 1ns / 1ps
// Checker for the refresh scheduler: mirrors its table, predicts every output word and compares.
module refresh_monitor #(
    parameter int ENTRIES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [39:0]                 i_s_tdata,
    input  logic [2:0]                  i_s_tuser,
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [71:0]                 i_m_tdata,
    input  logic [2:0]                  i_m_tuser,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [accdr_pkg::CFG_W-1:0] i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    import accdr_pkg::*;

    localparam int REPORT_MAX = 10;

    logic [13:0]       tab_addr   [ENTRIES];
    logic              tab_active [ENTRIES];
    logic [4:0]        tab_top    [ENTRIES];
    logic [31:0]       tab_pulse  [ENTRIES];
    logic [31:0]       tab_func   [ENTRIES];
    logic [3:0]        tab_seq    [ENTRIES];
    logic              tab_bound  [ENTRIES];
    logic [9:0]        tab_loco   [ENTRIES];
    logic [1:0]        tick_phase;
    int                rr_next;
    logic [ECNT_W-1:0] entry_count;
    logic [LCNT_W-1:0] loco_count;

    t_result packet_q[$];
    t_result seen;
    t_result want;
    t_item   cmd;
    int      mismatches = 0;
    int      k;

    function automatic t_result emit_packet(input logic [2:0] pk, input int e);
        t_result r;
        r = '0;
        r.packet_valid   = 1'b1;
        r.packet_kind    = pk;
        r.served_entry   = e[5:0];
        r.packet_address = tab_addr[e];
        if (pk == PK_SPEED) begin
            r.speed_source_loco = tab_loco[e];
        end else begin
            r.function_bits = tab_func[e];
        end
        return r;
    endfunction

    // Applies one command to the mirrored table and returns the word it should produce.
    function automatic t_result predict_packet(input logic [2:0] kind, input t_item it);
        t_result     r;
        int          n;
        int          e;
        int          i;
        logic        done;
        logic        req;
        logic [3:0]  pos;
        logic [4:0]  top;
        logic [2:0]  grp;
        logic [31:0] bit_mask;
        r        = '0;
        e        = it.entry;
        n        = (entry_count > ENTRIES) ? ENTRIES : entry_count;
        bit_mask = 32'd1 << it.function_number;
        if (kind != KIND_TICK && e >= ENTRIES) begin
            return r;
        end
        case (kind)
            KIND_TICK: begin
                done = 1'b1;
                if (tick_phase == 2'd0) begin
                    if (rr_next < n) begin
                        if (tab_active[rr_next] && tab_addr[rr_next] != '0) begin
                            pos = tab_seq[rr_next];
                            top = tab_top[rr_next];
                            if (!pos[0]) begin
                                if (tab_bound[rr_next]) r = emit_packet(PK_SPEED, rr_next);
                            end else begin
                                case (pos)
                                    4'd1: r = emit_packet(PK_F0_4, rr_next);
                                    4'd3: if (top >= TOP_F5) r = emit_packet(PK_F5_8, rr_next);
                                    4'd5: if (top >= TOP_F9) r = emit_packet(PK_F9_12, rr_next);
                                    4'd7: if (top >= TOP_F13) r = emit_packet(PK_F13_20, rr_next);
                                    default: if (top >= TOP_F21) r = emit_packet(PK_F21_28, rr_next);
                                endcase
                            end
                            // sequence position moves on even when nothing went out
                            tab_seq[rr_next] = (pos + 4'd1 >= SEQ_LEN) ? 4'd0 : pos + 4'd1;
                        end
                        rr_next++;
                        if (rr_next >= n) begin
                            rr_next = 0;
                        end else begin
                            done = 1'b0;
                        end
                    end else begin
                        rr_next = 0;
                    end
                end
                tick_phase    = tick_phase + 2'd1;
                r.cycle_done  = done;
            end
            KIND_WRITE: begin
                tab_addr[e]   = it.dcc_address;
                tab_active[e] = it.enable;
            end
            KIND_BIND: begin
                if (it.unbind) begin
                    tab_bound[e] = 1'b0;
                end else if (it.loco_number < loco_count) begin
                    // a loco is bound to one entry at most; the scan covers entries in use
                    for (i = 0; i < n; i++) begin
                        if (i != e && tab_bound[i] && tab_loco[i] == it.loco_number) begin
                            tab_bound[i] = 1'b0;
                        end
                    end
                    tab_bound[e] = 1'b1;
                    tab_loco[e]  = it.loco_number;
                end
            end
            KIND_FTYPE: begin
                if (tab_top[e] < it.function_number) tab_top[e] = it.function_number;
                if (it.flag) begin
                    tab_pulse[e] = tab_pulse[e] | bit_mask;
                end else begin
                    tab_pulse[e] = tab_pulse[e] & ~bit_mask;
                end
            end
            KIND_SETF: begin
                req = 1'b0;
                if (it.flag) begin
                    tab_func[e] = tab_func[e] | bit_mask;
                    req = (bit_mask & tab_pulse[e]) != '0;
                end else begin
                    tab_func[e] = tab_func[e] & ~bit_mask;
                end
                if (it.function_number <= GRP_END_1) grp = PK_F0_4;
                else if (it.function_number <= GRP_END_2) grp = PK_F5_8;
                else if (it.function_number <= GRP_END_3) grp = PK_F9_12;
                else if (it.function_number <= GRP_END_4) grp = PK_F13_20;
                else if (it.function_number <= GRP_END_5) grp = PK_F21_28;
                else grp = PK_F29_36;
                // sent regardless of active flag or address
                r = emit_packet(grp, e);
                r.pulse_reset_request = req;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic note_failure(input string what, input t_result exp_w, input t_result got_w);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("%0t %s: exp valid=%0d kind=%0d entry=%0d addr=%0d loco=%0d func=%h",
                     $realtime, what, exp_w.packet_valid, exp_w.packet_kind,
                     exp_w.served_entry, exp_w.packet_address, exp_w.speed_source_loco,
                     exp_w.function_bits);
            $display("    exp pulse=%0d done=%0d | got valid=%0d kind=%0d entry=%0d addr=%0d",
                     exp_w.pulse_reset_request, exp_w.cycle_done, got_w.packet_valid,
                     got_w.packet_kind, got_w.served_entry, got_w.packet_address);
            $display("    got loco=%0d func=%h pulse=%0d done=%0d",
                     got_w.speed_source_loco, got_w.function_bits,
                     got_w.pulse_reset_request, got_w.cycle_done);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (k = 0; k < ENTRIES; k++) begin
                tab_addr[k]   = '0;
                tab_active[k] = 1'b0;
                tab_top[k]    = '0;
                tab_pulse[k]  = '0;
                tab_func[k]   = '0;
                tab_seq[k]    = '0;
                tab_bound[k]  = 1'b0;
                tab_loco[k]   = '0;
            end
            tick_phase  = '0;
            rr_next     = 0;
            entry_count = '0;
            loco_count  = '0;
            packet_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ENTRY_COUNT) begin
                    entry_count = i_cfg_data[ECNT_W-1:0];
                end else begin
                    loco_count = i_cfg_data[LCNT_W-1:0];
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                seen.packet_valid        = i_m_tdata[0];
                seen.packet_kind         = i_m_tuser;
                seen.served_entry        = i_m_tdata[6:1];
                seen.packet_address      = i_m_tdata[20:7];
                seen.speed_source_loco   = i_m_tdata[30:21];
                seen.function_bits       = i_m_tdata[62:31];
                seen.pulse_reset_request = i_m_tdata[63];
                seen.cycle_done          = i_m_tdata[64];
                if (packet_q.size() == 0) begin
                    note_failure("unexpected word", '0, seen);
                end else begin
                    want = packet_q.pop_front();
                    if (seen !== want) note_failure("word mismatch", want, seen);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                cmd.entry           = i_s_tdata[5:0];
                cmd.dcc_address     = i_s_tdata[19:6];
                cmd.enable          = i_s_tdata[20];
                cmd.loco_number     = i_s_tdata[30:21];
                cmd.unbind          = i_s_tdata[31];
                cmd.function_number = i_s_tdata[36:32];
                cmd.flag            = i_s_tdata[37];
                packet_q.insert(packet_q.size(), predict_packet(i_s_tuser, cmd));
            end
        end
        o_pending    <= packet_q.size();
        o_fail_count <= mismatches;
    end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Testbench top: drives commands and configuration into the refresh scheduler and reports.
module tb;
    import accdr_pkg::*;

    localparam int         CYCLE_LIMIT   = 600000;
    localparam int         PHASES        = 6;
    localparam int         PHASE_WORDS   = 325;
    localparam logic [2:0] KIND_BAD_HI   = 3'd7;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [39:0]      s_tdata   = '0;
    logic [2:0]       s_tuser   = KIND_TICK;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [71:0]      m_tdata;
    logic [2:0]       m_tuser;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = CFG_ENTRY_COUNT;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             s_took    = 1'b0;
    int               fail_count;
    int               pending;
    int               send_idle = 0;
    int               recv_idle = 0;
    int               cycles    = 0;
    int               ec_tab [PHASES] = '{4, 64, 1, 0, 7, 3};
    int               lc_tab [PHASES] = '{1024, 1024, 1, 0, 12, 1024};
    int               p;

    accessory_decoder_refresh_scheduler u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    refresh_monitor u_monitor (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // input handshake seen at the last rising edge
    always @(posedge clk) begin
        s_took <= s_tvalid && s_tready;
    end

    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_word(input logic [2:0] kind, input logic [5:0] ent,
                             input logic [13:0] adr, input logic en, input logic [9:0] loco,
                             input logic unb, input logic [4:0] fn, input logic flg);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, flg, fn, unb, loco, en, adr, ent};
        do @(negedge clk); while (!s_took);
    endtask

    task automatic set_config(input int ec, input int lc);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ENTRY_COUNT;
        cfg_data  <= CFG_W'(ec);
        @(negedge clk);
        cfg_index <= CFG_LOCO_COUNT;
        cfg_data  <= CFG_W'(lc);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly commands on entries in use with colliding loco numbers, so binds steal.
    task automatic random_word(input int ec, input int lc);
        int          pick;
        int          sel;
        logic [2:0]  kind;
        logic [5:0]  ent;
        logic [13:0] adr;
        logic [9:0]  loco;
        pick = $urandom_range(99);
        if (pick < 52) kind = KIND_TICK;
        else if (pick < 62) kind = KIND_WRITE;
        else if (pick < 72) kind = KIND_BIND;
        else if (pick < 82) kind = KIND_FTYPE;
        else if (pick < 97) kind = KIND_SETF;
        else kind = KIND_SETF + 3'($urandom_range(3, 1));
        if (ec > 0 && $urandom_range(9) < 8) ent = 6'($urandom_range(ec - 1));
        else ent = 6'($urandom_range(63));
        sel = $urandom_range(9);
        if (sel == 0) adr = '0;
        else if (sel == 1) adr = 14'd10239;
        else adr = 14'($urandom_range(10239, 1));
        sel = $urandom_range(9);
        if (lc > 0 && sel < 5) loco = 10'($urandom_range((lc > 8) ? 7 : lc - 1));
        else if (lc > 0 && sel < 9) loco = 10'($urandom_range((lc > 1024) ? 1023 : lc - 1));
        else loco = 10'($urandom_range(1023));
        send_word(kind, ent, adr, $urandom_range(9) != 0, loco, $urandom_range(7) == 0,
                  5'($urandom_range(31)), 1'($urandom_range(1)));
    endtask

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (p = 0; p < PHASES; p++) begin
            if (p < 2) begin
                send_idle = 23;
                recv_idle = 58;
            end else if (p < 4) begin
                send_idle = 58;
                recv_idle = 23;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            set_config(ec_tab[p], lc_tab[p]);
            if (p == 0) begin
                send_word(KIND_WRITE, 6'd0, 14'd10239, 1'b1, '0, 1'b0, '0, 1'b0);
                send_word(KIND_WRITE, 6'd1, 14'd1, 1'b1, '0, 1'b0, '0, 1'b0);
                // entry outside the round robin with address zero
                send_word(KIND_WRITE, 6'd63, 14'd0, 1'b1, '0, 1'b0, '0, 1'b0);
                send_word(KIND_WRITE, 6'd2, 14'd8192, 1'b0, '0, 1'b0, '0, 1'b0);
                send_word(KIND_BIND, 6'd0, '0, 1'b0, 10'd1023, 1'b0, '0, 1'b0);
                // same loco to another entry takes it away from the first
                send_word(KIND_BIND, 6'd1, '0, 1'b0, 10'd1023, 1'b0, '0, 1'b0);
                send_word(KIND_BIND, 6'd0, '0, 1'b0, 10'd0, 1'b0, '0, 1'b0);
                send_word(KIND_BIND, 6'd2, '0, 1'b0, 10'd1023, 1'b1, '0, 1'b0);
                send_word(KIND_FTYPE, 6'd0, '0, 1'b0, '0, 1'b0, 5'd31, 1'b1);
                send_word(KIND_FTYPE, 6'd0, '0, 1'b0, '0, 1'b0, 5'd0, 1'b1);
                send_word(KIND_FTYPE, 6'd1, '0, 1'b0, '0, 1'b0, 5'd21, 1'b0);
                send_word(KIND_SETF, 6'd0, '0, 1'b0, '0, 1'b0, 5'd0, 1'b1);
                send_word(KIND_SETF, 6'd0, '0, 1'b0, '0, 1'b0, 5'd31, 1'b1);
                send_word(KIND_SETF, 6'd1, '0, 1'b0, '0, 1'b0, 5'd5, 1'b1);
                send_word(KIND_SETF, 6'd1, '0, 1'b0, '0, 1'b0, 5'd9, 1'b1);
                send_word(KIND_SETF, 6'd1, '0, 1'b0, '0, 1'b0, 5'd13, 1'b1);
                send_word(KIND_SETF, 6'd1, '0, 1'b0, '0, 1'b0, 5'd28, 1'b1);
                send_word(KIND_SETF, 6'd0, '0, 1'b0, '0, 1'b0, 5'd0, 1'b0);
                send_word(KIND_SETF, 6'd63, '0, 1'b0, '0, 1'b0, 5'd20, 1'b1);
                send_word(KIND_BAD_HI, 6'd63, 14'd10239, 1'b1, 10'd1023, 1'b1, 5'd31, 1'b1);
                repeat (8) send_word(KIND_TICK, '0, '0, 1'b0, '0, 1'b0, '0, 1'b0);
            end
            repeat (PHASE_WORDS) random_word(ec_tab[p], lc_tab[p]);
            s_tvalid <= 1'b0;
            while (pending != 0) @(negedge clk);
            repeat (10) @(negedge clk);
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
